[rtl/core/fpsp_pkg.sv]
// Shared types and constants for the farthest point subset picker.
package fpsp_pkg;

    localparam int MAX_CANDIDATES_DEF = 4096;
    localparam int MAX_DIMS_DEF       = 8;

    localparam int COORD_W  = 16;
    localparam int INDEX_W  = 12;
    localparam int DIMS_W   = 4;
    localparam int PICKS_W  = 7;
    localparam int CFG_W    = 7;
    localparam int DIST_W   = 35;
    localparam int SQ_W     = 2 * COORD_W;

    localparam logic [PICKS_W-1:0] RESULT_LIMIT = 7'd64;
    localparam logic [DIMS_W-1:0]  DIMS_RESET   = 4'd3;
    localparam logic [PICKS_W-1:0] PICKS_RESET  = 7'd1;
    localparam logic [DIST_W-1:0]  DIST_MAX     = {DIST_W{1'b1}};

    typedef enum logic [0:0] {
        REG_POINT_DIMS = 1'b0,
        REG_PICK_COUNT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] coordinate;
        logic               set_end;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] picked_index;
        logic               final_pick;
    } out_item_t;

endpackage

[rtl/core/farthest_point_subset_picker_core.sv]
// Farthest point subset picker: loads candidate points, then emits picks in farthest-first order.
// Coordinates load at one request per cycle, while the core is idle, into the point store. The
// request with set_end closes the set; if the set holds a complete point and the pick count is
// nonzero, the core stalls its input until the run's last pick enters the output register.
// Selection runs on one shared subtract/square/accumulate unit stepped by a sequencer over
// one-read, one-write memories: each pick copies the D pivot coordinates, then reads the D
// coordinates of each of the L live candidates (D the point dimension, L the live count). Picks
// leave through an output register, so a stalled result holds the core only at the next pick.
module farthest_point_subset_picker_core #(
    parameter int MAX_CANDIDATES = fpsp_pkg::MAX_CANDIDATES_DEF,
    parameter int MAX_DIMS       = fpsp_pkg::MAX_DIMS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  fpsp_pkg::reg_index_t          cfg_index,
    input  logic [fpsp_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  fpsp_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output fpsp_pkg::out_item_t           out_data
);

    localparam int IDXW = $clog2(MAX_CANDIDATES);
    localparam int CNTW = $clog2(MAX_CANDIDATES + 1);
    localparam int DW   = $clog2(MAX_DIMS + 1);
    localparam int DIW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int PSD  = MAX_CANDIDATES * MAX_DIMS;
    localparam int SAW  = $clog2(PSD);

    typedef enum logic [3:0] {
        S_IDLE, S_EMIT, S_PIV_RD, S_PIV_WR, S_ORG_RD, S_ORG_WR, S_DIM_RD,
        S_DIM_SQ, S_DIM_ACC, S_ND_RD, S_ND_UP, S_SW1, S_SW2, S_SW3
    } state_t;

    state_t                         state_reg, state_next;
    logic [fpsp_pkg::DIMS_W-1:0]    dims_reg;
    logic [fpsp_pkg::PICKS_W-1:0]   pick_cnt_reg;
    logic [CNTW-1:0]                loaded_reg, loaded_next;
    logic [DW-1:0]                  pos_reg, pos_next;
    logic [fpsp_pkg::PICKS_W-1:0]   picks_reg, picks_next;
    logic [IDXW-1:0]                live_reg, live_next;
    logic [IDXW-1:0]                slot_reg, slot_next;
    logic [DW-1:0]                  dim_reg, dim_next;
    logic [IDXW-1:0]                best_reg, best_next;
    logic [fpsp_pkg::DIST_W-1:0]    best_val_reg, best_val_next;
    logic [fpsp_pkg::DIST_W-1:0]    acc_reg, acc_next;
    logic [fpsp_pkg::SQ_W-1:0]      prod_reg, prod_next;
    logic [IDXW-1:0]                origin_reg, origin_next;
    logic [IDXW-1:0]                pivot_org_reg, pivot_org_next;
    logic                           init_reg, init_next;
    logic                           out_valid_reg, out_valid_next;
    fpsp_pkg::out_item_t            out_data_reg, out_data_next;
    logic [fpsp_pkg::COORD_W-1:0]   pivot_reg [MAX_DIMS];
    logic                           pivot_we;

    logic [fpsp_pkg::COORD_W-1:0]   ps_mem [PSD];
    logic [IDXW-1:0]                so_mem [MAX_CANDIDATES];
    logic [fpsp_pkg::DIST_W-1:0]    nd_mem [MAX_CANDIDATES];

    logic                           ps_we, so_we, nd_we;
    logic [SAW-1:0]                 ps_waddr, ps_raddr;
    logic [IDXW-1:0]                so_waddr, so_raddr, nd_waddr, nd_raddr;
    logic [fpsp_pkg::COORD_W-1:0]   ps_wdata, ps_rd;
    logic [IDXW-1:0]                so_wdata, so_rd;
    logic [fpsp_pkg::DIST_W-1:0]    nd_wdata, nd_rd;

    logic [DW-1:0]                  dims_use;
    logic [fpsp_pkg::PICKS_W-1:0]   want;
    logic                           in_fire;
    logic [DW-1:0]                  pos_inc;
    logic                           point_done;
    logic [CNTW-1:0]                loaded_after;
    logic [CNTW-1:0]                last_full;
    logic [DW-1:0]                  dim_inc;
    logic                           dim_last;
    logic [fpsp_pkg::COORD_W-1:0]   pivot_coord;
    logic [fpsp_pkg::COORD_W-1:0]   diff;
    logic [fpsp_pkg::DIST_W:0]      acc_sum;
    logic [fpsp_pkg::DIST_W-1:0]    new_dist;
    logic                           fin;

    function automatic logic [SAW-1:0] store_addr(input logic [IDXW-1:0] pt,
                                                  input logic [DW-1:0] d);
        store_addr = SAW'(SAW'(pt) * SAW'(MAX_DIMS)) + SAW'(d[DIW-1:0]);
    endfunction

    assign dims_use = (dims_reg == '0) ? DW'(1) :
                      (32'(dims_reg) > MAX_DIMS) ? DW'(MAX_DIMS) : DW'(dims_reg);
    assign want     = (pick_cnt_reg > fpsp_pkg::RESULT_LIMIT) ? fpsp_pkg::RESULT_LIMIT
                                                              : pick_cnt_reg;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign pos_inc      = pos_reg + DW'(1);
    assign point_done   = (pos_inc >= dims_use);
    assign loaded_after = loaded_reg +
                          CNTW'(point_done && (32'(loaded_reg) < MAX_CANDIDATES));
    assign last_full    = loaded_after - CNTW'(1);
    assign dim_inc      = dim_reg + DW'(1);
    assign dim_last     = (dim_inc == dims_use);
    assign pivot_coord  = pivot_reg[dim_reg[DIW-1:0]];
    assign diff         = (ps_rd >= pivot_coord) ? (ps_rd - pivot_coord)
                                                 : (pivot_coord - ps_rd);
    assign acc_sum      = {1'b0, acc_reg} + (fpsp_pkg::DIST_W + 1)'(prod_reg);
    assign new_dist     = (init_reg || (acc_reg < nd_rd)) ? acc_reg : nd_rd;
    assign fin          = !((picks_reg + 7'd1 < want) && (live_reg != '0));

    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        pos_next       = pos_reg;
        picks_next     = picks_reg;
        live_next      = live_reg;
        slot_next      = slot_reg;
        dim_next       = dim_reg;
        best_next      = best_reg;
        best_val_next  = best_val_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        origin_next    = origin_reg;
        pivot_org_next = pivot_org_reg;
        init_next      = init_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pivot_we       = 1'b0;
        ps_we    = 1'b0;
        ps_waddr = store_addr(loaded_reg[IDXW-1:0], pos_reg);
        ps_wdata = in_data.coordinate;
        ps_raddr = store_addr(origin_reg, dim_reg);
        so_we    = 1'b0;
        so_waddr = slot_reg;
        so_wdata = slot_reg;
        so_raddr = slot_reg;
        nd_we    = 1'b0;
        nd_waddr = slot_reg;
        nd_wdata = new_dist;
        nd_raddr = slot_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ps_we       = (32'(loaded_reg) < MAX_CANDIDATES);
                    loaded_next = loaded_after;
                    pos_next    = point_done ? '0 : pos_inc;
                    if (in_data.set_end)
                    begin
                        pos_next    = '0;
                        picks_next  = '0;
                        loaded_next = '0;
                        if ((want != '0) && (loaded_after != '0))
                        begin
                            pivot_org_next = last_full[IDXW-1:0];
                            live_next      = last_full[IDXW-1:0];
                            init_next      = 1'b1;
                            state_next     = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.picked_index = fpsp_pkg::INDEX_W'(pivot_org_reg);
                    out_data_next.final_pick   = fin;
                    dim_next                   = '0;
                    if (fin)
                    begin
                        picks_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        picks_next = picks_reg + 7'd1;
                        state_next = S_PIV_RD;
                    end
                end
            end
            S_PIV_RD:
            begin
                ps_raddr   = store_addr(pivot_org_reg, dim_reg);
                state_next = S_PIV_WR;
            end
            S_PIV_WR:
            begin
                pivot_we = 1'b1;
                if (dim_last)
                begin
                    slot_next     = '0;
                    best_next     = '0;
                    best_val_next = '0;
                    state_next    = S_ORG_RD;
                end
                else
                begin
                    dim_next   = dim_inc;
                    state_next = S_PIV_RD;
                end
            end
            S_ORG_RD:
            begin
                // first pass after load fills slots with their own index
                so_we      = init_reg;
                state_next = S_ORG_WR;
            end
            S_ORG_WR:
            begin
                origin_next = init_reg ? slot_reg : so_rd;
                dim_next    = '0;
                acc_next    = '0;
                state_next  = S_DIM_RD;
            end
            S_DIM_RD:
            begin
                state_next = S_DIM_SQ;
            end
            S_DIM_SQ:
            begin
                prod_next  = diff * diff;
                state_next = S_DIM_ACC;
            end
            S_DIM_ACC:
            begin
                acc_next = acc_sum[fpsp_pkg::DIST_W] ? fpsp_pkg::DIST_MAX
                                                     : acc_sum[fpsp_pkg::DIST_W-1:0];
                if (dim_last)
                begin
                    state_next = S_ND_RD;
                end
                else
                begin
                    dim_next   = dim_inc;
                    state_next = S_DIM_RD;
                end
            end
            S_ND_RD:
            begin
                state_next = S_ND_UP;
            end
            S_ND_UP:
            begin
                nd_we = 1'b1;
                // strict compare keeps the lowest slot on ties
                if ((slot_reg == '0) || (new_dist > best_val_reg))
                begin
                    best_next     = slot_reg;
                    best_val_next = new_dist;
                end
                if (slot_reg + IDXW'(1) == live_reg)
                begin
                    init_next  = 1'b0;
                    state_next = S_SW1;
                end
                else
                begin
                    slot_next  = slot_reg + IDXW'(1);
                    state_next = S_ORG_RD;
                end
            end
            S_SW1:
            begin
                so_raddr   = best_reg;
                state_next = S_SW2;
            end
            S_SW2:
            begin
                pivot_org_next = so_rd;
                so_raddr       = live_reg - IDXW'(1);
                nd_raddr       = live_reg - IDXW'(1);
                state_next     = S_SW3;
            end
            S_SW3:
            begin
                // last live slot moves into the picked one
                so_we      = 1'b1;
                so_waddr   = best_reg;
                so_wdata   = so_rd;
                nd_we      = 1'b1;
                nd_waddr   = best_reg;
                nd_wdata   = nd_rd;
                live_next  = live_reg - IDXW'(1);
                state_next = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dims_reg      <= fpsp_pkg::DIMS_RESET;
            pick_cnt_reg  <= fpsp_pkg::PICKS_RESET;
            loaded_reg    <= '0;
            pos_reg       <= '0;
            picks_reg     <= '0;
            live_reg      <= '0;
            slot_reg      <= '0;
            dim_reg       <= '0;
            best_reg      <= '0;
            best_val_reg  <= '0;
            acc_reg       <= '0;
            prod_reg      <= '0;
            origin_reg    <= '0;
            pivot_org_reg <= '0;
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            pos_reg       <= pos_next;
            picks_reg     <= picks_next;
            live_reg      <= live_next;
            slot_reg      <= slot_next;
            dim_reg       <= dim_next;
            best_reg      <= best_next;
            best_val_reg  <= best_val_next;
            acc_reg       <= acc_next;
            prod_reg      <= prod_next;
            origin_reg    <= origin_next;
            pivot_org_reg <= pivot_org_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    fpsp_pkg::REG_POINT_DIMS: dims_reg     <= cfg_data[fpsp_pkg::DIMS_W-1:0];
                    fpsp_pkg::REG_PICK_COUNT: pick_cnt_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pivot_we)
        begin
            pivot_reg[dim_reg[DIW-1:0]] <= ps_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ps_we)
        begin
            ps_mem[ps_waddr] <= ps_wdata;
        end
        ps_rd <= ps_mem[ps_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (so_we)
        begin
            so_mem[so_waddr] <= so_wdata;
        end
        so_rd <= so_mem[so_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nd_we)
        begin
            nd_mem[nd_waddr] <= nd_wdata;
        end
        nd_rd <= nd_mem[nd_raddr];
    end

`ifndef SYNTHESIS
    a_rose_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result appeared outside emit");

    a_best_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SW1) |-> (best_reg < live_reg))
        else $error("best slot not live");

    a_picks_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (picks_reg < want))
        else $error("pick count overrun");
`endif

endmodule

[test/fpsp_checker.sv]
// Checker for the farthest point subset picker: watches the channels, predicts picks, compares.
module fpsp_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  fpsp_pkg::reg_index_t       cfg_index,
    input  logic [fpsp_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  fpsp_pkg::in_item_t         in_data,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  fpsp_pkg::out_item_t        out_data,
    output int                         errors,
    output int                         pending
);

    localparam int NCAND = fpsp_pkg::MAX_CANDIDATES_DEF;
    localparam int NDIM  = fpsp_pkg::MAX_DIMS_DEF;

    logic [fpsp_pkg::COORD_W-1:0] pt_store [0:NCAND*NDIM-1];
    logic [fpsp_pkg::DIST_W-1:0]  near_dist [0:NCAND-1];
    logic [fpsp_pkg::INDEX_W-1:0] origin_of [0:NCAND-1];
    int                           n_loaded;
    int                           coord_pos;
    logic [fpsp_pkg::DIMS_W-1:0]  dims_reg;
    logic [fpsp_pkg::PICKS_W-1:0] picks_reg;
    fpsp_pkg::out_item_t          pick_q [$];

    function automatic logic [fpsp_pkg::DIST_W-1:0] sq_dist(int a, int b, int dims);
        logic [63:0] sum;
        logic [63:0] diff;
        sum = 0;
        for (int d = 0; d < dims; d++)
        begin
            if (pt_store[a*NDIM+d] > pt_store[b*NDIM+d])
                diff = pt_store[a*NDIM+d] - pt_store[b*NDIM+d];
            else
                diff = pt_store[b*NDIM+d] - pt_store[a*NDIM+d];
            sum += diff * diff;
        end
        if (sum > fpsp_pkg::DIST_MAX)
            return fpsp_pkg::DIST_MAX;
        return sum[fpsp_pkg::DIST_W-1:0];
    endfunction

    task automatic select_picks(int dims);
        int want;
        int live;
        int last_slot;
        int best;
        int made;
        logic [fpsp_pkg::INDEX_W-1:0] org;
        logic [fpsp_pkg::INDEX_W-1:0] tmp_o;
        logic [fpsp_pkg::DIST_W-1:0]  tmp_d;
        logic [fpsp_pkg::DIST_W-1:0]  d;
        fpsp_pkg::out_item_t          item;
        want = int'((picks_reg > fpsp_pkg::RESULT_LIMIT) ? fpsp_pkg::RESULT_LIMIT
                                                         : picks_reg);
        if (want == 0 || n_loaded == 0)
        begin
            n_loaded = 0;
            return;
        end
        last_slot = n_loaded - 1;
        live = last_slot;
        for (int i = 0; i < live; i++)
        begin
            origin_of[i] = fpsp_pkg::INDEX_W'(i);
            near_dist[i] = sq_dist(i, last_slot, dims);
        end
        item.picked_index = fpsp_pkg::INDEX_W'(last_slot);
        item.final_pick = 1'b0;
        pick_q = {pick_q, item};
        made = 1;
        while (made < want && live > 0)
        begin
            best = 0;
            for (int i = 1; i < live; i++)
                if (near_dist[i] > near_dist[best])
                    best = i;
            org = origin_of[best];
            item.picked_index = org;
            pick_q = {pick_q, item};
            made++;
            live--;
            // picked slot leaves by swapping with the last live slot
            tmp_o = origin_of[best];
            origin_of[best] = origin_of[live];
            origin_of[live] = tmp_o;
            tmp_d = near_dist[best];
            near_dist[best] = near_dist[live];
            near_dist[live] = tmp_d;
            for (int i = 0; i < live; i++)
            begin
                d = sq_dist(int'(origin_of[i]), int'(org), dims);
                if (d < near_dist[i])
                    near_dist[i] = d;
            end
        end
        pick_q[pick_q.size()-1].final_pick = 1'b1;
        n_loaded = 0;
    endtask

    task automatic load_coord(fpsp_pkg::in_item_t it);
        int dims;
        dims = (dims_reg == 0) ? 1 : (int'(dims_reg) > NDIM) ? NDIM : int'(dims_reg);
        if (n_loaded < NCAND && coord_pos < NDIM)
            pt_store[n_loaded*NDIM+coord_pos] = it.coordinate;
        coord_pos++;
        if (coord_pos >= dims)
        begin
            coord_pos = 0;
            if (n_loaded < NCAND)
                n_loaded++;
        end
        if (it.set_end)
        begin
            coord_pos = 0;
            select_picks(dims);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_loaded = 0;
            coord_pos = 0;
            dims_reg = fpsp_pkg::DIMS_RESET;
            picks_reg = fpsp_pkg::PICKS_RESET;
            errors = 0;
            pick_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == fpsp_pkg::REG_POINT_DIMS)
                    dims_reg = cfg_data[fpsp_pkg::DIMS_W-1:0];
                else
                    picks_reg = cfg_data[fpsp_pkg::PICKS_W-1:0];
            end
            if (out_valid && !out_stall)
            begin
                if (pick_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected pick: index %0d final %0b",
                                 out_data.picked_index, out_data.final_pick);
                end
                else
                begin
                    if (out_data !== pick_q[0])
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("pick mismatch: exp index %0d final %0b, got %0d %0b",
                                     pick_q[0].picked_index, pick_q[0].final_pick,
                                     out_data.picked_index, out_data.final_pick);
                    end
                    void'(pick_q.pop_front());
                end
            end
            if (in_valid && !in_stall)
                load_coord(in_data);
            pending = pick_q.size();
        end
    end

endmodule

[test/tb_farthest_point_subset_picker_core.sv]
// Testbench top for the farthest point subset picker: stimulus, receiver stalls and verdict.
module tb_farthest_point_subset_picker_core;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    fpsp_pkg::reg_index_t       cfg_index;
    logic [fpsp_pkg::CFG_W-1:0] cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    fpsp_pkg::in_item_t         in_data;
    logic                       out_valid;
    logic                       out_stall;
    fpsp_pkg::out_item_t        out_data;
    int                         errors;
    int                         pending;

    int src_idle;
    int sink_stall;
    bit hold_req;
    int items_sent;

    farthest_point_subset_picker_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    fpsp_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60000000;
        $display("tb_farthest_point_subset_picker_core NOT OK");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        bit held;
        held = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1;
                repeat (3000)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < sink_stall);
        end
    end

    task automatic send(logic [fpsp_pkg::COORD_W-1:0] c, int e);
        while ($urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.coordinate <= c;
        in_data.set_end <= (e != 0);
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic cfg_write(fpsp_pkg::reg_index_t idx, int val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= fpsp_pkg::CFG_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [fpsp_pkg::COORD_W-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1: return fpsp_pkg::COORD_W'($urandom_range(3) * 16'h4000);
            default: return fpsp_pkg::COORD_W'($urandom);
        endcase
    endfunction

    // one candidate set: npts full points, then 'extra' trailing coordinates
    task automatic send_set(int npts, int dims, int extra, int mode);
        int total;
        int k;
        total = npts * dims + extra;
        k = 0;
        for (int p = 0; p < npts; p++)
            for (int d = 0; d < dims; d++)
            begin
                k++;
                send(rand_coord(mode), int'(k == total));
            end
        for (int x = 0; x < extra; x++)
        begin
            k++;
            send(rand_coord(mode), int'(k == total));
        end
    endtask

    initial
    begin
        int dims;
        int setno;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = fpsp_pkg::REG_POINT_DIMS;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        src_idle = 0;
        sink_stall = 0;
        hold_req = 0;
        items_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 3 dims, one pick
        send(16'h0000, 0); send(16'hFFFF, 0); send(16'h1234, 0);
        send(16'hFFFF, 1);
        cfg_write(fpsp_pkg::REG_PICK_COUNT, 4);
        // extremes and ties: identical points
        send(16'hFFFF, 0); send(16'hFFFF, 0); send(16'hFFFF, 0);
        send(16'hFFFF, 0); send(16'hFFFF, 0); send(16'hFFFF, 0);
        send(16'h0000, 0); send(16'h0000, 0); send(16'h0000, 1);
        // no complete point
        send(16'hAAAA, 1);
        cfg_write(fpsp_pkg::REG_PICK_COUNT, 0);
        send(16'h5555, 0); send(16'h0001, 0); send(16'h8000, 1);
        // dims zero acts as one; pick count above the limit
        cfg_write(fpsp_pkg::REG_POINT_DIMS, 0);
        cfg_write(fpsp_pkg::REG_PICK_COUNT, 127);
        send(16'h0000, 0); send(16'hFFFF, 0); send(16'h8000, 1);
        // dims above the maximum act as the maximum
        cfg_write(fpsp_pkg::REG_POINT_DIMS, 15);
        send_set(2, 8, 3, 2);
        // dimension lowered mid-point
        cfg_write(fpsp_pkg::REG_POINT_DIMS, 4);
        cfg_write(fpsp_pkg::REG_PICK_COUNT, 3);
        send_set(2, 4, 0, 2);
        send(16'h0100, 0); send(16'hF000, 0);
        cfg_write(fpsp_pkg::REG_POINT_DIMS, 2);
        send(16'h7777, 0); send(16'h0F0F, 0); send(16'hF0F0, 1);

        // random sets with rotating idle phases; long hold-off in the second set
        setno = 0;
        while (items_sent < 480)
        begin
            case (setno % 4)
                0: begin src_idle = 0;  sink_stall = 0;  end
                1: begin src_idle = 86; sink_stall = 0;  end
                2: begin src_idle = 0;  sink_stall = 86; end
                default: begin src_idle = 21; sink_stall = 21; end
            endcase
            if (setno % 5 == 0)
            begin
                dims = (setno % 3 == 0) ? $urandom_range(15) : $urandom_range(1, 3);
                cfg_write(fpsp_pkg::REG_POINT_DIMS, dims);
                cfg_write(fpsp_pkg::REG_PICK_COUNT,
                          ($urandom_range(9) == 0) ? $urandom_range(127)
                                                   : $urandom_range(1, 16));
            end
            else
                dims = int'(chk.dims_reg);
            dims = (dims == 0) ? 1 : (dims > 8) ? 8 : dims;
            if (setno == 1)
                hold_req = 1;
            send_set($urandom_range(1, 12), dims,
                     ($urandom_range(3) == 0) ? $urandom_range(dims - 1) : 0,
                     $urandom_range(3));
            setno++;
        end

        wait_idle();
        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_farthest_point_subset_picker_core OK");
        else
            $display("tb_farthest_point_subset_picker_core NOT OK");
        $finish;
    end

endmodule
